### rtl/core/form_urlencoded_decoder_defines.svh
// assertion macros used by the decoder top level
`ifndef FORM_URLENCODED_DECODER_DEFINES_SVH
`define FORM_URLENCODED_DECODER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FUD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("form decoder check failed");

// next-cycle implication, disabled in reset
`define FUD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("form decoder check failed");

`endif

### rtl/core/fud_pkg.sv
`default_nettype none

package fud_pkg;

  // separators and escape characters
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [4:0] HEX_TEN  = 5'd10;

  // results per request and result queue sizing
  localparam int MAX_RES = 4;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int QDEPTH  = 8;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // escape progress
  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } fud_esc_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       end_of_body;
  } fud_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       in_value;
    logic       key_end;
    logic       pair_end;
    logic       body_done;
    logic       last_of_run;
  } fud_out_t;

  typedef fud_out_t [MAX_RES-1:0] fud_res_t;

  // decoder state as seen by the top level
  typedef struct packed {
    logic       value_phase;
    fud_esc_t   escape_stage;
    logic [7:0] held_digit;
  } fud_state_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } fud_hex_t;

  // hex digit of either case
  function automatic fud_hex_t hex_of(input logic [7:0] c);
    fud_hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h61 + 8'(HEX_TEN));
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h41 + 8'(HEX_TEN));
    end
    return h;
  endfunction

  // one result entry, last_of_run filled in later
  function automatic fud_out_t mk(input logic [7:0] b, input logic has, input logic inval,
                                  input logic ke, input logic pe, input logic bd);
    fud_out_t r;
    r.out_byte    = has ? b : 8'd0;
    r.has_byte    = has;
    r.in_value    = inval;
    r.key_end     = ke;
    r.pair_end    = pe;
    r.body_done   = bd;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/form_urlencoded_decoder.sv
// each result is written into the result queue as its body byte is accepted
// throughput: one byte per cycle while out_ready is high and each byte yields
// at most one result; the single read port of the eight-entry result queue drains
// one result a cycle and input stalls whenever fewer than four entries are free
// reset: synchronous active-low rst_n clears the decoder state and empties the queue
`default_nettype none
`include "form_urlencoded_decoder_defines.svh"

module form_urlencoded_decoder (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fud_pkg::fud_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fud_pkg::fud_out_t      out_data
);
  import fud_pkg::*;

  logic              take;
  fud_res_t          res;
  logic [CNT_W-1:0]  res_cnt;
  fud_state_t        state;
  logic [QCNT_W-1:0] q_count;

  // accept only with room for a full burst
  assign in_ready = (q_count <= QCNT_W'(QDEPTH - MAX_RES));
  assign take     = in_valid && in_ready;

  fud_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_item (in_data),
    .res     (res),
    .res_cnt (res_cnt),
    .state   (state)
  );

  fud_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (take),
    .wr_cnt   (res_cnt),
    .wr_data  (res),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (out_data),
    .count    (q_count)
  );

  // checks
  `FUD_ASSERT_IMPL(a_queue_bound, clk, rst_n, 1'b1, q_count <= QCNT_W'(QDEPTH))
  `FUD_ASSERT_NEXT(a_body_end_resets, clk, rst_n, take && in_data.end_of_body, !state.value_phase && state.escape_stage == ESC_NONE)
  `FUD_ASSERT_NEXT(a_body_end_result, clk, rst_n, take && in_data.end_of_body, out_valid)

endmodule

`default_nettype wire

### rtl/core/fud_decode.sv
`default_nettype none

module fud_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire fud_pkg::fud_in_t  in_item,
  output fud_pkg::fud_res_t      res,
  output logic [fud_pkg::CNT_W-1:0] res_cnt,
  output fud_pkg::fud_state_t    state
);
  import fud_pkg::*;

  logic       value_phase_r, value_phase_nxt;
  fud_esc_t   escape_stage_r, escape_stage_nxt;
  logic [7:0] held_digit_r, held_digit_nxt;

  logic [7:0]       c;
  logic             last;
  fud_hex_t         hc;
  fud_hex_t         hh;
  fud_esc_t         es;
  logic [7:0]       hd;
  logic             vp;
  logic [CNT_W-1:0] n;
  fud_res_t         r;
  logic [1:0]       tail;

  // decode one body byte into up to four results
  always_comb begin
    c    = in_item.body_byte;
    last = in_item.end_of_body;
    hc   = hex_of(c);
    hh   = hex_of(held_digit_r);
    vp   = value_phase_r;
    hd   = held_digit_r;
    n    = '0;
    r    = '0;
    tail = '0;
    // a stage of three never occurs and reads as no escape
    unique case (escape_stage_r)
      ESC_PCT:   es = ESC_PCT;
      ESC_DIGIT: es = ESC_DIGIT;
      default:   es = ESC_NONE;
    endcase

    if (c == CH_AMP || (c == CH_EQ && !vp)) begin
      // separator: flush a pending escape, then the marker
      if (es != ESC_NONE) begin
        r[n[1:0]] = mk(CH_PCT, 1'b1, vp, 1'b0, 1'b0, 1'b0);
        n = n + 1'b1;
      end
      if (es == ESC_DIGIT) begin
        r[n[1:0]] = mk(hd, 1'b1, vp, 1'b0, 1'b0, 1'b0);
        n = n + 1'b1;
      end
      es = ESC_NONE;
      hd = 8'd0;
      if (c == CH_AMP) begin
        r[n[1:0]] = mk(8'd0, 1'b0, vp, 1'b0, 1'b1, last);
        n = n + 1'b1;
        vp = 1'b0;
      end else begin
        r[n[1:0]] = mk(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        n = n + 1'b1;
        vp = 1'b1;
        if (last) begin
          r[n[1:0]] = mk(8'd0, 1'b0, vp, 1'b0, 1'b1, 1'b1);
          n = n + 1'b1;
          vp = 1'b0;
        end
      end
    end else begin
      // data byte: advance or break a pending escape
      if (es == ESC_PCT && hc.ok) begin
        hd = c;
        es = ESC_DIGIT;
      end else if (es == ESC_DIGIT && hc.ok) begin
        r[n[1:0]] = mk({(hh.ok ? hh.val : 4'd0), hc.val}, 1'b1, vp, 1'b0, 1'b0, 1'b0);
        n = n + 1'b1;
        es = ESC_NONE;
        hd = 8'd0;
      end else begin
        // broken escape goes out literally, byte read afresh
        if (es != ESC_NONE) begin
          r[n[1:0]] = mk(CH_PCT, 1'b1, vp, 1'b0, 1'b0, 1'b0);
          n = n + 1'b1;
        end
        if (es == ESC_DIGIT) begin
          r[n[1:0]] = mk(hd, 1'b1, vp, 1'b0, 1'b0, 1'b0);
          n = n + 1'b1;
          hd = 8'd0;
        end
        es = ESC_NONE;
        if (c == CH_PCT) begin
          es = ESC_PCT;
        end else begin
          r[n[1:0]] = mk((c == CH_PLUS) ? CH_SPACE : c, 1'b1, vp, 1'b0, 1'b0, 1'b0);
          n = n + 1'b1;
        end
      end
      // end of body closes the pair
      if (last) begin
        if (es != ESC_NONE) begin
          r[n[1:0]] = mk(CH_PCT, 1'b1, vp, 1'b0, 1'b0, 1'b0);
          n = n + 1'b1;
        end
        if (es == ESC_DIGIT) begin
          r[n[1:0]] = mk(hd, 1'b1, vp, 1'b0, 1'b0, 1'b0);
          n = n + 1'b1;
        end
        r[n[1:0]] = mk(8'd0, 1'b0, vp, 1'b0, 1'b1, 1'b1);
        n = n + 1'b1;
      end
    end

    // body end returns to the reset state
    if (last) begin
      vp = 1'b0;
      es = ESC_NONE;
      hd = 8'd0;
    end

    // flag the final result of this request
    if (n != '0) begin
      tail = 2'(n - 1'b1);
      r[tail].last_of_run = 1'b1;
    end

    value_phase_nxt  = vp;
    escape_stage_nxt = es;
    held_digit_nxt   = hd;
  end

  assign res     = r;
  assign res_cnt = n;

  assign state.value_phase  = value_phase_r;
  assign state.escape_stage = escape_stage_r;
  assign state.held_digit   = held_digit_r;

  // decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      value_phase_r  <= 1'b0;
      escape_stage_r <= ESC_NONE;
      held_digit_r   <= 8'd0;
    end else if (take) begin
      value_phase_r  <= value_phase_nxt;
      escape_stage_r <= escape_stage_nxt;
      held_digit_r   <= held_digit_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/core/fud_out_queue.sv
`default_nettype none

module fud_out_queue (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wr_en,
  input  wire logic [fud_pkg::CNT_W-1:0]  wr_cnt,
  input  wire fud_pkg::fud_res_t          wr_data,
  output logic                            rd_valid,
  input  wire logic                       rd_ready,
  output fud_pkg::fud_out_t               rd_data,
  output logic [fud_pkg::QCNT_W-1:0]      count
);
  import fud_pkg::*;

  fud_out_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic [QPTR_W-1:0]  addr [MAX_RES];
  logic [CNT_W-1:0]   n_in;
  logic               pop;

  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign count    = count_r;
  assign pop      = rd_valid && rd_ready;
  assign n_in     = wr_en ? wr_cnt : '0;

  // slot addresses for a burst of writes
  always_comb begin
    for (int i = 0; i < MAX_RES; i++) begin
      addr[i] = wr_ptr_r + QPTR_W'(i);
    end
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(n_in);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    count_nxt  = count_r + QCNT_W'(n_in) - QCNT_W'(pop);
  end

  // entry storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (CNT_W'(i) < n_in) begin
        mem_r[addr[i]] <= wr_data[i];
      end
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire
